/* design/kdr_pkg.sv */
// ----------------------------------------------------------------------------
// kdr_pkg: shared definitions for the karyotype division rule core
// Widths, row depth, register indexes and copy change codes.
// ----------------------------------------------------------------------------
package kdr_pkg;

  // Row depth and the widths that follow from it
  localparam int unsigned MaxChrom = 64;
  localparam int unsigned IdxW     = (MaxChrom > 1) ? $clog2(MaxChrom) : 1;
  localparam int unsigned CntW     = $clog2(MaxChrom + 1);

  // Field widths
  localparam int unsigned ProbW   = 17;
  localparam int unsigned CopiesW = 8;
  localparam int unsigned DrawW   = 16;
  localparam int unsigned DaughW  = 4;
  localparam int unsigned OutcW   = 2;
  localparam int unsigned ProdW   = ProbW + CopiesW;
  localparam int unsigned CfgIdxW = 1;

  // Largest legal copy count of a daughter
  localparam logic [CopiesW-1:0] MaxCount = CopiesW'(8);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMissegProb   = 1'b0;
  localparam logic [CfgIdxW-1:0] RegDoublingProb = 1'b1;

  // Per-chromosome copy change, as stored
  typedef enum logic [1:0] {
    ChNone = 2'd0,
    ChUp   = 2'd1,
    ChDown = 2'd2
  } change_e;

  // Division outcome
  typedef enum logic [OutcW-1:0] {
    OutBoth    = 2'd0,
    OutOne     = 2'd1,
    OutRemoved = 2'd2
  } outcome_e;

endpackage

/* design/karyotype_division_rule_core.sv */
// ----------------------------------------------------------------------------
// karyotype_division_rule_core: division rule over one karyotype row
// Loads a parent row, tests doubling and missegregation, replays daughters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one chromosome per
//   transfer; row_end_i marks the last one of a row. The doubling draws are
//   read on the first element of each row.
//   Each element is taken in a transfer step and then computed in the
//   shared multiply-compare unit, which also writes the row memory.
//   After the row_end element the row is replayed from the row memory, one
//   result per stored chromosome, each through a memory read, output form and
//   output transfer step; the receiver can stall the transfer. in_stall_o stays
//   high for the whole replay. Elements beyond the row depth are not stored.
//   Output channel (out_valid_o / out_stall_i): the result is held in the
//   output register for as long as out_stall_i is high.
//   Configuration port (cfg_valid_i / cfg_ready_o) is always ready; write
//   it only while the block is idle.
//   Reset clears the control state and both probabilities; the block is
//   ready for an input transfer as soon as reset is released.
// ----------------------------------------------------------------------------
module karyotype_division_rule_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration port
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kdr_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [kdr_pkg::ProbW-1:0]         cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [kdr_pkg::CopiesW-1:0]       copies_i,
  input  logic [kdr_pkg::DrawW-1:0]         misseg_draw_i,
  input  logic                              sign_draw_i,
  input  logic [kdr_pkg::DrawW-1:0]         doubling_draw_i,
  input  logic                              keep_draw_i,
  input  logic                              row_end_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [kdr_pkg::OutcW-1:0]         outcome_o,
  output logic [kdr_pkg::DaughW-1:0]        first_daughter_o,
  output logic [kdr_pkg::DaughW-1:0]        second_daughter_o,
  output logic                              last_out_o
);

  typedef enum logic [2:0] {
    StIdle,
    StCalc,
    StRead,
    StForm,
    StHold
  } state_e;

  localparam int unsigned MemW = kdr_pkg::CopiesW + 2;

  state_e                          state_q;
  logic [kdr_pkg::ProbW-1:0]       misseg_prob_q, doubling_prob_q;
  logic [kdr_pkg::CntW-1:0]        cnt_q;
  logic [kdr_pkg::IdxW-1:0]        idx_q;
  logic                            dbl_q, keep_q;
  logic [1:0]                      valid_q;
  kdr_pkg::outcome_e               outcome_q;

  // latched input element
  logic [kdr_pkg::CopiesW-1:0]     copies_q;
  logic [kdr_pkg::DrawW-1:0]       mdraw_q, ddraw_q;
  logic                            sign_q, keep_in_q, end_q;

  // row memory: {change, parent}
  logic [MemW-1:0]                 mem_q [kdr_pkg::MaxChrom];
  logic [MemW-1:0]                 rd_q;
  logic                            mem_we;
  logic [MemW-1:0]                 mem_wdata;

  // output register
  logic                            out_valid_q;
  logic [kdr_pkg::OutcW-1:0]       outcome_out_q;
  logic [kdr_pkg::DaughW-1:0]      first_q, second_q;
  logic                            last_q;

  // element compute
  logic                            first_elem, dbl_now, keep_now, stored, miss;
  logic [kdr_pkg::ProdW-1:0]       prod;
  kdr_pkg::change_e                ch;
  logic                            v1_ok, v2_ok;
  logic [1:0]                      valid_new;
  kdr_pkg::outcome_e               outcome_new;

  // replay
  logic [kdr_pkg::CopiesW-1:0]     rd_parent;
  kdr_pkg::change_e                rd_change;
  logic [kdr_pkg::DaughW-1:0]      d1, d2, f_val, g_val;
  logic                            is_last;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);

  // Shared multiply-compare unit and range checks for the latched element
  always_comb begin
    first_elem = (cnt_q == '0);
    dbl_now    = first_elem ? ({1'b0, ddraw_q} < doubling_prob_q) : dbl_q;
    keep_now   = first_elem ? keep_in_q : keep_q;
    stored     = (cnt_q < kdr_pkg::CntW'(kdr_pkg::MaxChrom));
    prod       = kdr_pkg::ProdW'(misseg_prob_q) * kdr_pkg::ProdW'(copies_q);
    miss       = (kdr_pkg::ProdW'(mdraw_q) < prod);
    ch         = kdr_pkg::ChNone;
    if (!dbl_now && miss) begin
      ch = sign_q ? kdr_pkg::ChUp : kdr_pkg::ChDown;
    end
    // first daughter p+s, second p-s, both must lie in 0..8
    unique case (ch)
      kdr_pkg::ChUp: begin
        v1_ok = (copies_q < kdr_pkg::MaxCount);
        v2_ok = (copies_q != '0) && (copies_q <= kdr_pkg::MaxCount + 1'b1);
      end
      kdr_pkg::ChDown: begin
        v1_ok = (copies_q != '0) && (copies_q <= kdr_pkg::MaxCount + 1'b1);
        v2_ok = (copies_q < kdr_pkg::MaxCount);
      end
      default: begin
        v1_ok = (copies_q <= kdr_pkg::MaxCount);
        v2_ok = v1_ok;
      end
    endcase
    valid_new = valid_q;
    if (stored) begin
      if (dbl_now) begin
        if (copies_q > (kdr_pkg::MaxCount >> 1)) valid_new[0] = 1'b0;
      end else begin
        if (!v1_ok) valid_new[0] = 1'b0;
        if (!v2_ok) valid_new[1] = 1'b0;
      end
    end
    // outcome of the row from the final flags
    if (dbl_now) begin
      outcome_new = (!keep_now || !valid_new[0]) ? kdr_pkg::OutRemoved : kdr_pkg::OutOne;
    end else if (valid_new == 2'b11) begin
      outcome_new = kdr_pkg::OutBoth;
    end else if (valid_new != 2'b00) begin
      outcome_new = kdr_pkg::OutOne;
    end else begin
      outcome_new = kdr_pkg::OutRemoved;
    end
    mem_we    = (state_q == StCalc) && stored;
    mem_wdata = {ch, copies_q};
  end

  // Form one daughter pair from the memory read data
  always_comb begin
    rd_parent = rd_q[kdr_pkg::CopiesW-1:0];
    rd_change = kdr_pkg::change_e'(rd_q[MemW-1 -: 2]);
    if (dbl_q) begin
      d1 = {rd_parent[kdr_pkg::DaughW-2:0], 1'b0};
      d2 = '0;
    end else begin
      unique case (rd_change)
        kdr_pkg::ChUp: begin
          d1 = rd_parent[kdr_pkg::DaughW-1:0] + kdr_pkg::DaughW'(1);
          d2 = rd_parent[kdr_pkg::DaughW-1:0] - kdr_pkg::DaughW'(1);
        end
        kdr_pkg::ChDown: begin
          d1 = rd_parent[kdr_pkg::DaughW-1:0] - kdr_pkg::DaughW'(1);
          d2 = rd_parent[kdr_pkg::DaughW-1:0] + kdr_pkg::DaughW'(1);
        end
        default: begin
          d1 = rd_parent[kdr_pkg::DaughW-1:0];
          d2 = rd_parent[kdr_pkg::DaughW-1:0];
        end
      endcase
    end
    unique case (outcome_q)
      kdr_pkg::OutBoth: begin
        f_val = d1;
        g_val = d2;
      end
      kdr_pkg::OutOne: begin
        f_val = (dbl_q || valid_q[0]) ? d1 : d2;
        g_val = '0;
      end
      default: begin
        f_val = '0;
        g_val = '0;
      end
    endcase
    is_last = ((kdr_pkg::CntW'(idx_q) + kdr_pkg::CntW'(1)) == cnt_q);
  end

  // Row memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cnt_q[kdr_pkg::IdxW-1:0]] <= mem_wdata;
    end
    rd_q <= mem_q[idx_q];
  end

  // Latch the element on its transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      copies_q  <= copies_i;
      mdraw_q   <= misseg_draw_i;
      sign_q    <= sign_draw_i;
      ddraw_q   <= doubling_draw_i;
      keep_in_q <= keep_draw_i;
      end_q     <= row_end_i;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      misseg_prob_q   <= '0;
      doubling_prob_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        kdr_pkg::RegMissegProb:   misseg_prob_q   <= cfg_data_i;
        kdr_pkg::RegDoublingProb: doubling_prob_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer: load, compute, then replay the row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      cnt_q         <= '0;
      idx_q         <= '0;
      dbl_q         <= 1'b0;
      keep_q        <= 1'b0;
      valid_q       <= 2'b11;
      outcome_q     <= kdr_pkg::OutBoth;
      out_valid_q   <= 1'b0;
      outcome_out_q <= '0;
      first_q       <= '0;
      second_q      <= '0;
      last_q        <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) state_q <= StCalc;
        end
        StCalc: begin
          dbl_q   <= dbl_now;
          keep_q  <= keep_now;
          valid_q <= valid_new;
          if (stored) cnt_q <= cnt_q + kdr_pkg::CntW'(1);
          if (end_q) begin
            outcome_q <= outcome_new;
            idx_q     <= '0;
            state_q   <= StRead;
          end else begin
            state_q <= StIdle;
          end
        end
        StRead: begin
          state_q <= StForm;
        end
        StForm: begin
          outcome_out_q <= outcome_q;
          first_q       <= f_val;
          second_q      <= g_val;
          last_q        <= is_last;
          out_valid_q   <= 1'b1;
          state_q       <= StHold;
        end
        StHold: begin
          // hold the result until the receiver takes it
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (last_q) begin
              cnt_q   <= '0;
              dbl_q   <= 1'b0;
              keep_q  <= 1'b0;
              valid_q <= 2'b11;
              state_q <= StIdle;
            end else begin
              idx_q   <= idx_q + kdr_pkg::IdxW'(1);
              state_q <= StRead;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign outcome_o         = outcome_out_q;
  assign first_daughter_o  = first_q;
  assign second_daughter_o = second_q;
  assign last_out_o        = last_q;

endmodule

/* design/kdr_checker.sv */
// ----------------------------------------------------------------------------
// kdr_checker: port-level checks for the karyotype division rule core
// Watches the channels of the top level and flags illegal behaviour.
// ----------------------------------------------------------------------------
module kdr_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic [kdr_pkg::CfgIdxW-1:0]       cfg_index_i,
  input logic [kdr_pkg::ProbW-1:0]         cfg_data_i,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [kdr_pkg::CopiesW-1:0]       copies_i,
  input logic [kdr_pkg::DrawW-1:0]         misseg_draw_i,
  input logic                              sign_draw_i,
  input logic [kdr_pkg::DrawW-1:0]         doubling_draw_i,
  input logic                              keep_draw_i,
  input logic                              row_end_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [kdr_pkg::OutcW-1:0]         outcome_o,
  input logic [kdr_pkg::DaughW-1:0]        first_daughter_o,
  input logic [kdr_pkg::DaughW-1:0]        second_daughter_o,
  input logic                              last_out_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(outcome_o)
      && $stable(first_daughter_o) && $stable(second_daughter_o) && $stable(last_out_o))
    else $error("stalled result changed");

  // No input transfer while a result is being replayed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken during replay");

  // Outcome code within range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (outcome_o != 2'd3))
    else $error("illegal outcome code");

  // Unused daughter fields read as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o != kdr_pkg::OutBoth) |-> (second_daughter_o == '0))
    else $error("second daughter not cleared");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == kdr_pkg::OutRemoved) |-> (first_daughter_o == '0))
    else $error("first daughter not cleared on removal");

endmodule

bind karyotype_division_rule_core kdr_checker u_kdr_checker (.*);
